// ===== rtl/core/legb_pkg.sv =====
// ----------------------------------------------------------------------------
// legb_pkg: shared definitions for the line edit gap buffer
// Operation codes, status codes, field widths and the default capacity.
// ----------------------------------------------------------------------------
package legb_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam int FUNC_W   = 3;
	localparam int CHAR_W   = 8;
	localparam int RDPOS_W  = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// Operation codes carried in func.
	localparam logic [FUNC_W-1:0] FN_LEFT      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_RIGHT     = 3'd1;
	localparam logic [FUNC_W-1:0] FN_BACKSPACE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;

	// Status codes of a result word.
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BOUNDARY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd3;

endpackage

// ===== rtl/core/line_edit_gap_buffer.sv =====
// ----------------------------------------------------------------------------
// line_edit_gap_buffer: character line buffer with a cursor
// Keeps a line of text as a gap buffer in one synchronous memory and runs
// one edit or read operation per input word, returning one result word.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Fields
//   --------+-----------+--------------------+--------------------------------
//   in      | input     | in_valid/in_stall  | func, char_in, read_position
//   out     | output    | out_valid/out_stall| status, char_out, text_length,
//           |           |                    | cursor_position
//
// Backspace, insert, refused operations and reads beyond the text load the
// result register straight on acceptance. Cursor moves and successful reads
// also pass through S_MEM, set by the single memory port pair: the entry is
// read on acceptance and its registered data is written back or returned in S_MEM.
// Reset clears the cursor and gap pointers; the memory itself is not cleared,
// since only entries that hold text are ever read.
// A stalled result blocks the next input word; the word that frees it may
// enter on the same edge as the result leaves.

module line_edit_gap_buffer #(
	parameter int CAPACITY = legb_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [legb_pkg::FUNC_W-1:0]    func,
	input  logic [legb_pkg::CHAR_W-1:0]    char_in,
	input  logic [legb_pkg::RDPOS_W-1:0]   read_position,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [legb_pkg::STATUS_W-1:0]  status,
	output logic [legb_pkg::CHAR_W-1:0]    char_out,
	output logic [legb_pkg::COUNT_W-1:0]   text_length,
	output logic [legb_pkg::COUNT_W-1:0]   cursor_position
);
	import legb_pkg::*;

	// AW addresses one entry; PW holds a pointer that may equal CAPACITY.
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	// Controller states.
	localparam logic S_IDLE = 1'b0;
	localparam logic S_MEM  = 1'b1;

	// Kind of the operation that waits for memory data.
	localparam logic [1:0] PK_LEFT  = 2'd0;
	localparam logic [1:0] PK_RIGHT = 2'd1;
	localparam logic [1:0] PK_READ  = 2'd2;

	// The text store, written and read in one clocked block.
	logic [CHAR_W-1:0] mem [CAPACITY];

	logic                state_q;
	logic [1:0]          pend_s1;
	logic [PW-1:0]       gs_q;
	logic [PW-1:0]       ge_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CHAR_W-1:0]   char_q;
	logic [CHAR_W-1:0]   rdata_s1;

	logic                in_acc;
	logic                out_free;
	logic [PW-1:0]       text_len;
	logic [PW-1:0]       gs_dec;
	logic [PW-1:0]       ge_dec;
	logic [31:0]         rd_pos_ext;
	logic [31:0]         rd_far_idx;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [CHAR_W-1:0]   wr_data;
	logic [31:0]         len_ext;
	logic [31:0]         cur_ext;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// Text length is the part left of the gap plus the part right of it.
	assign text_len   = gs_q + (CAP_P - ge_q);
	assign gs_dec     = gs_q - PW'(1);
	assign ge_dec     = ge_q - PW'(1);
	assign rd_pos_ext = 32'(read_position);
	// A position at or past the cursor lies beyond the gap.
	assign rd_far_idx = 32'(ge_q) + rd_pos_ext - 32'(gs_q);

	// Memory port selection: reads start on acceptance, writes happen either
	// on acceptance (insert) or in the S_MEM state of a cursor move.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = char_in;
		if (state_q == S_MEM) begin
			if (pend_s1 == PK_LEFT) begin
				wr_en   = 1'b1;
				wr_addr = ge_dec[AW-1:0];
				wr_data = rdata_s1;
			end else if (pend_s1 == PK_RIGHT) begin
				wr_en   = 1'b1;
				wr_addr = gs_q[AW-1:0];
				wr_data = rdata_s1;
			end
		end else if (in_acc) begin
			case (func)
				FN_LEFT: begin
					rd_en   = (gs_q != '0);
					rd_addr = gs_dec[AW-1:0];
				end
				FN_RIGHT: begin
					rd_en   = (ge_q != CAP_P);
					rd_addr = ge_q[AW-1:0];
				end
				FN_INSERT: begin
					wr_en   = (gs_q != ge_q);
					wr_addr = gs_q[AW-1:0];
				end
				FN_READ: begin
					rd_en = (rd_pos_ext < 32'(text_len));
					if (rd_pos_ext < 32'(gs_q)) begin
						rd_addr = rd_pos_ext[AW-1:0];
					end else begin
						rd_addr = rd_far_idx[AW-1:0];
					end
				end
				default: begin
					rd_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Controller, gap pointers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_s1     <= PK_LEFT;
			gs_q        <= '0;
			ge_q        <= CAP_P;
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			char_q      <= '0;
		end else begin
			if (state_q == S_MEM) begin
				// Memory data is back: finish the move or the read. The result
				// register is empty here, since the word was only taken when
				// the register was free.
				state_q     <= S_IDLE;
				out_valid_q <= 1'b1;
				status_q    <= ST_DONE;
				case (pend_s1)
					PK_LEFT: begin
						gs_q   <= gs_dec;
						ge_q   <= ge_dec;
						char_q <= '0;
					end
					PK_RIGHT: begin
						gs_q   <= gs_q + PW'(1);
						ge_q   <= ge_q + PW'(1);
						char_q <= '0;
					end
					PK_READ: begin
						char_q <= rdata_s1;
					end
					default: begin
						char_q <= '0;
					end
				endcase
			end else if (in_acc) begin
				// An accepted word finds the result register free or leaving,
				// so each arm sets its valid afresh.
				char_q <= '0;
				case (func)
					FN_LEFT: begin
						if (gs_q == '0) begin
							out_valid_q <= 1'b1;
							status_q    <= ST_BOUNDARY;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= S_MEM;
							pend_s1     <= PK_LEFT;
						end
					end
					FN_RIGHT: begin
						if (ge_q == CAP_P) begin
							out_valid_q <= 1'b1;
							status_q    <= ST_BOUNDARY;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= S_MEM;
							pend_s1     <= PK_RIGHT;
						end
					end
					FN_BACKSPACE: begin
						out_valid_q <= 1'b1;
						if (gs_q == '0) begin
							status_q <= ST_BOUNDARY;
						end else begin
							status_q <= ST_DONE;
							gs_q     <= gs_dec;
						end
					end
					FN_INSERT: begin
						out_valid_q <= 1'b1;
						if (gs_q == ge_q) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_DONE;
							gs_q     <= gs_q + PW'(1);
						end
					end
					FN_READ: begin
						if (rd_pos_ext < 32'(text_len)) begin
							out_valid_q <= 1'b0;
							state_q     <= S_MEM;
							pend_s1     <= PK_READ;
						end else begin
							out_valid_q <= 1'b1;
							status_q    <= ST_BEYOND;
						end
					end
					default: begin
						out_valid_q <= 1'b1;
						status_q    <= ST_BOUNDARY;
					end
				endcase
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The pointers only move when a result is loaded, so the counts shown
	// with a result are taken straight from them.
	assign len_ext         = 32'(text_len);
	assign cur_ext         = 32'(gs_q);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign char_out        = char_q;
	assign text_length     = len_ext[COUNT_W-1:0];
	assign cursor_position = cur_ext[COUNT_W-1:0];

endmodule

// ===== rtl/core/legb_checker.sv =====
// ----------------------------------------------------------------------------
// legb_checker: port-level checks for the line edit gap buffer
// Watches the result channel and the input handshake and attaches to the top level by a bind.
// ----------------------------------------------------------------------------
module legb_checker #(
	parameter int CAPACITY = legb_pkg::CAPACITY_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [legb_pkg::STATUS_W-1:0]  status,
	input logic [legb_pkg::CHAR_W-1:0]    char_out,
	input logic [legb_pkg::COUNT_W-1:0]   text_length,
	input logic [legb_pkg::COUNT_W-1:0]   cursor_position
);
	import legb_pkg::*;

	localparam bit COUNTS_FIT = (CAPACITY < (1 << COUNT_W));

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// The cursor never lies beyond the end of the text.
	a_cursor_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && COUNTS_FIT |-> cursor_position <= text_length)
		else $error("cursor beyond end of text");

	// Only a successful read returns a character.
	a_char_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_out != '0) |-> status == ST_DONE)
		else $error("character returned with a failing status");

	// While a result is held back, no new input word is taken.
	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall || !in_valid)
		else $error("input word taken while result stalled");

endmodule

bind line_edit_gap_buffer legb_checker #(.CAPACITY(CAPACITY)) u_legb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.char_out        (char_out),
	.text_length     (text_length),
	.cursor_position (cursor_position)
);
